// ===== hw/rtl/bcmt_pkg.sv =====
// shared types, constants and codes for the bucket counter max tracker
package bcmt_pkg;

    // default configuration
    localparam int NUM_BUCKETS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 16;

    // opcodes
    localparam logic [1:0] OP_INC  = 2'd0;
    localparam logic [1:0] OP_DEC  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_SAT   = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] bucket_index;
        logic       is_omega;
    } in_item_t;

    typedef struct packed {
        logic [15:0] bucket_count;
        logic [7:0]  top_index;
        logic        top_valid;
        logic        top_is_omega;
        logic [1:0]  error_code;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
        logic walk;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_walk;
        logic walk_done;
    } sts_t;

endpackage

// ===== hw/rtl/bcmt_ctrl.sv =====
// controller state machine for the bucket counter max tracker
module bcmt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output bcmt_pkg::cmd_t cmd,
    input  bcmt_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.need_walk ? ST_WALK : ST_FINISH;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready_next = (state_next == ST_IDLE);
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/bcmt_datapath.sv =====
// datapath of the bucket counter max tracker: count memory, omega count, top mark
module bcmt_datapath #(
    parameter int NUM_BUCKETS = bcmt_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = bcmt_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bcmt_pkg::in_item_t  in_data,
    input  bcmt_pkg::cmd_t      cmd,
    output bcmt_pkg::sts_t      sts,
    output bcmt_pkg::out_item_t out_data
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [NUM_BUCKETS];

    // captured transaction
    logic [1:0]            op_reg;
    logic [7:0]            idx_reg;
    logic                  omega_reg;

    logic [COUNT_BITS-1:0] rdata_reg;
    logic [COUNT_BITS-1:0] omega_cnt_reg;
    logic [COUNT_BITS-1:0] omega_cnt_next;
    logic [IDX_W-1:0]      hi_reg;
    logic [IDX_W-1:0]      hi_next;
    logic                  hv_reg;
    logic                  hv_next;
    logic [IDX_W-1:0]      clr_ptr_reg;
    logic [IDX_W-1:0]      clr_ptr_next;
    logic [IDX_W-1:0]      walk_ptr_reg;
    logic [IDX_W-1:0]      walk_ptr_next;
    logic [15:0]           res_cnt_reg;
    logic [1:0]            res_err_reg;
    bcmt_pkg::out_item_t   out_reg;

    logic [IDX_W-1:0]      addr;
    logic [IDX_W-1:0]      rd_addr;
    logic                  in_range;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [1:0]            err;
    logic                  inc_ok;
    logic                  dec_ok;
    logic                  mem_we;
    logic                  top_emptied;
    logic                  need_walk;
    logic                  drop_top;

    assign addr     = IDX_W'(idx_reg);
    assign in_range = omega_reg || (32'(idx_reg) < 32'(NUM_BUCKETS));
    assign cur      = omega_reg ? omega_cnt_reg : rdata_reg;

    // read-modify-write of the addressed count
    always_comb
    begin
        new_cnt = cur;
        err     = bcmt_pkg::ERR_OK;
        inc_ok  = 1'b0;
        dec_ok  = 1'b0;
        case (op_reg)
            bcmt_pkg::OP_INC:
            begin
                if (cur == CNT_MAX)
                begin
                    err = bcmt_pkg::ERR_SAT;
                end
                else
                begin
                    new_cnt = cur + 1'b1;
                    inc_ok  = 1'b1;
                end
            end
            bcmt_pkg::OP_DEC:
            begin
                if (cur == '0)
                begin
                    err = bcmt_pkg::ERR_UNDER;
                end
                else
                begin
                    new_cnt = cur - 1'b1;
                    dec_ok  = 1'b1;
                end
            end
            default:
            begin
                new_cnt = cur;
            end
        endcase
        if (!in_range)
        begin
            err    = bcmt_pkg::ERR_OK;
            inc_ok = 1'b0;
            dec_ok = 1'b0;
        end
    end

    assign mem_we      = cmd.update && !omega_reg && (inc_ok || dec_ok);
    assign top_emptied = dec_ok && !omega_reg && hv_reg && (addr == hi_reg) && (new_cnt == '0);
    assign need_walk   = top_emptied && (hi_reg != '0);
    assign drop_top    = top_emptied && (hi_reg == '0);

    assign sts.need_walk  = need_walk;
    assign sts.walk_done  = (rdata_reg != '0) || (walk_ptr_reg == '0);
    assign sts.clear_last = (clr_ptr_reg == IDX_W'(NUM_BUCKETS - 1));

    // walk reads one bucket ahead of the one being checked
    always_comb
    begin
        if (cmd.capture)
        begin
            rd_addr = IDX_W'(in_data.bucket_index);
        end
        else if (cmd.update)
        begin
            rd_addr = hi_reg - 1'b1;
        end
        else
        begin
            rd_addr = walk_ptr_reg - 1'b1;
        end
    end

    always_comb
    begin
        hi_next        = hi_reg;
        hv_next        = hv_reg;
        omega_cnt_next = omega_cnt_reg;
        clr_ptr_next   = clr_ptr_reg;
        walk_ptr_next  = walk_ptr_reg;
        if (cmd.clear)
        begin
            clr_ptr_next = clr_ptr_reg + 1'b1;
        end
        if (cmd.update)
        begin
            walk_ptr_next = hi_reg - 1'b1;
            if (omega_reg && (inc_ok || dec_ok))
            begin
                omega_cnt_next = new_cnt;
            end
            if (inc_ok && !omega_reg && (!hv_reg || (addr > hi_reg)))
            begin
                hi_next = addr;
                hv_next = 1'b1;
            end
            if (drop_top)
            begin
                hi_next = '0;
                hv_next = 1'b0;
            end
        end
        if (cmd.walk)
        begin
            walk_ptr_next = walk_ptr_reg - 1'b1;
            if (rdata_reg != '0)
            begin
                hi_next = walk_ptr_reg;
            end
            else if (walk_ptr_reg == '0)
            begin
                hi_next = '0;
                hv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_ptr_reg] <= '0;
        end
        else if (mem_we)
        begin
            mem[addr] <= new_cnt;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg        <= '0;
            hv_reg        <= 1'b0;
            omega_cnt_reg <= '0;
            clr_ptr_reg   <= '0;
        end
        else
        begin
            hi_reg        <= hi_next;
            hv_reg        <= hv_next;
            omega_cnt_reg <= omega_cnt_next;
            clr_ptr_reg   <= clr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_ptr_reg <= walk_ptr_next;
        if (cmd.capture)
        begin
            op_reg    <= in_data.opcode;
            idx_reg   <= in_data.bucket_index;
            omega_reg <= in_data.is_omega;
        end
        if (cmd.update)
        begin
            res_cnt_reg <= in_range ? 16'(new_cnt) : 16'd0;
            res_err_reg <= err;
        end
        if (cmd.load_out)
        begin
            out_reg.bucket_count <= res_cnt_reg;
            out_reg.top_index    <= 8'(hi_reg);
            out_reg.top_valid    <= hv_reg;
            out_reg.top_is_omega <= (omega_cnt_reg != '0);
            out_reg.error_code   <= res_err_reg;
        end
    end

    assign out_data = out_reg;

    a_mark_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        !hv_reg |-> (hi_reg == '0))
        else $error("top mark nonzero while invalid");

    a_walk_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> hv_reg)
        else $error("walk running without a valid top mark");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.capture, cmd.update, cmd.walk, cmd.load_out}))
        else $error("more than one datapath command");

    a_inc_sets_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && inc_ok) |=> hv_reg)
        else $error("finite increment left top mark invalid");

    a_walk_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && (rdata_reg != '0)) |=> (hi_reg == $past(walk_ptr_reg)))
        else $error("walk stopped at the wrong bucket");

endmodule

// ===== hw/rtl/bucket_counter_max_tracker.sv =====
// top level of the bucket counter max tracker
// Keeps NUM_BUCKETS finite counters and one omega counter, each COUNT_BITS wide
// and saturating, and tracks the highest finite bucket whose count is nonzero.
// Every input transaction (increment, decrement or read) yields exactly one
// output transaction with the addressed count, the top mark and an error code.
// After reset the count memory is swept to zero, one bucket per cycle, and the
// block accepts nothing until the sweep is done. For an ordinary transaction the
// memory read happens at the accepting edge, followed by one update with
// write-back and then one output load before the result is offered. The block
// is ready again in the cycle after the output load. A decrement that empties
// the top bucket, unless that is bucket 0, adds a downward walk through the count
// memory, one bucket per cycle through its single read port and at most
// NUM_BUCKETS - 1 buckets, before the output load. The output load waits while
// an earlier result is still held by a stalled receiver.
// One transaction is in flight at a time; a finished result sits in the output
// register while the next transaction is accepted.
module bucket_counter_max_tracker #(
    parameter int NUM_BUCKETS = bcmt_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = bcmt_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bcmt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bcmt_pkg::out_item_t out_data
);

    // command and status between the state machine and the datapath
    bcmt_pkg::cmd_t cmd;
    bcmt_pkg::sts_t sts;

    bcmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bcmt_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
